### rtl/bankers_resource_allocator_top_defines.svh
// assertion macros used by the checker file
`ifndef BANKERS_RESOURCE_ALLOCATOR_TOP_DEFINES_SVH
`define BANKERS_RESOURCE_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define BRA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define BRA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bra_pkg.sv
package bra_pkg;

    localparam int CFG_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int AMT_W      = 8;
    localparam int CUST_W     = 3;
    localparam int FIELD_W    = 8;
    localparam int MAX_TYPES  = 3;
    localparam int CLAIM_REGS = 5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_UNITS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CLAIM0  = 3'd1;

    // command and status codes
    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_DENY = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic apply;
        logic step;
        logic revert;
        logic deny;
        logic emit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic pre_ok;
        logic is_req;
        logic none_fit;
        logic all_done;
    } t_dp_stat;

endpackage

### rtl/bra_ctrl.sv
module bra_ctrl import bra_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_ctl
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CHECK  = 5'b00010,
        S_PASS   = 5'b00100,
        S_REVERT = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        o_ctl       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_stat.pre_ok) begin
                    o_ctl.deny = 1'b1;
                    n_state    = S_FINISH;
                end else begin
                    o_ctl.apply = 1'b1;
                    n_state     = i_stat.is_req ? S_PASS : S_FINISH;
                end
            end
            S_PASS: begin
                if (i_stat.none_fit) begin
                    n_state = S_REVERT;
                end else begin
                    o_ctl.step = 1'b1;
                    if (i_stat.all_done) begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_REVERT: begin
                o_ctl.revert = 1'b1;
                o_ctl.deny   = 1'b1;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_ctl.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### rtl/bra_datapath.sv
module bra_datapath import bra_pkg::*; #(
    parameter int CUSTOMERS      = 5,
    parameter int RESOURCE_TYPES = 3,
    parameter int COUNT_WIDTH    = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_cmd,
    input  logic [CUST_W-1:0]    i_customer,
    input  logic [AMT_W-1:0]     i_amount_a,
    input  logic [AMT_W-1:0]     i_amount_b,
    input  logic [AMT_W-1:0]     i_amount_c,
    input  t_dp_cmd              i_ctl,
    output t_dp_stat             o_stat,
    output logic                 o_status,
    output logic [FIELD_W-1:0]   o_free_a,
    output logic [FIELD_W-1:0]   o_free_b,
    output logic [FIELD_W-1:0]   o_free_c
);

    // pool and summed holdings get three extra bits, room for up to 8 times a count
    localparam int SUM_W = COUNT_WIDTH + 3;

    logic [COUNT_WIDTH-1:0] r_total [RESOURCE_TYPES];
    logic [COUNT_WIDTH-1:0] r_claim [CUSTOMERS][RESOURCE_TYPES];
    logic [COUNT_WIDTH-1:0] r_held  [CUSTOMERS][RESOURCE_TYPES];
    logic [SUM_W-1:0]       r_used  [RESOURCE_TYPES];
    logic [SUM_W-1:0]       r_pool  [RESOURCE_TYPES];
    logic [CUSTOMERS-1:0]   r_retired;
    logic                   r_cmd;
    logic [CUST_W-1:0]      r_cust;
    logic [AMT_W-1:0]       r_amt   [RESOURCE_TYPES];
    logic                   r_deny;
    logic                   r_status;
    logic [FIELD_W-1:0]     r_free  [MAX_TYPES];

    logic [AMT_W-1:0]       amt_in   [MAX_TYPES];
    logic [CUSTOMERS-1:0]   sel;
    logic                   cust_ok;
    logic                   is_req;
    logic [COUNT_WIDTH-1:0] held_sel [RESOURCE_TYPES];
    logic [COUNT_WIDTH-1:0] claim_sel[RESOURCE_TYPES];
    logic [COUNT_WIDTH-1:0] left_sel [RESOURCE_TYPES];
    logic [COUNT_WIDTH-1:0] free_cnt [RESOURCE_TYPES];
    logic [COUNT_WIDTH-1:0] amt_cnt  [RESOURCE_TYPES];
    logic [RESOURCE_TYPES-1:0] amt_ok;
    logic [COUNT_WIDTH-1:0] need     [CUSTOMERS][RESOURCE_TYPES];
    logic [CUSTOMERS-1:0]   fit;
    logic [CUSTOMERS-1:0]   pick;
    logic [SUM_W-1:0]       back     [RESOURCE_TYPES];
    logic [FIELD_W-1:0]     free_ext [MAX_TYPES];
    logic                   held_upd;
    logic                   held_add;

    assign amt_in[0] = i_amount_a;
    assign amt_in[1] = i_amount_b;
    assign amt_in[2] = i_amount_c;

    assign cust_ok  = (r_cust < CUST_W'(CUSTOMERS));
    assign is_req   = (r_cmd == CMD_REQUEST);
    assign held_upd = i_ctl.apply || i_ctl.revert;
    assign held_add = i_ctl.apply && is_req;

    always_comb begin
        for (int c = 0; c < CUSTOMERS; c++) begin
            sel[c] = (r_cust == CUST_W'(c));
        end
    end

    // selected customer's row, free units and the request checks
    always_comb begin
        for (int r = 0; r < RESOURCE_TYPES; r++) begin
            held_sel[r]  = '0;
            claim_sel[r] = '0;
            for (int c = 0; c < CUSTOMERS; c++) begin
                if (sel[c]) begin
                    held_sel[r]  = held_sel[r] | r_held[c][r];
                    claim_sel[r] = claim_sel[r] | r_claim[c][r];
                end
            end
            left_sel[r] = (claim_sel[r] > held_sel[r]) ? claim_sel[r] - held_sel[r] : '0;
            free_cnt[r] = (SUM_W'(r_total[r]) > r_used[r]) ?
                          COUNT_WIDTH'(SUM_W'(r_total[r]) - r_used[r]) : '0;
            amt_cnt[r]  = r_amt[r][COUNT_WIDTH-1:0];
            if (is_req) begin
                amt_ok[r] = (r_amt[r] <= AMT_W'(left_sel[r])) &&
                            (r_amt[r] <= AMT_W'(free_cnt[r]));
            end else begin
                amt_ok[r] = (r_amt[r] <= AMT_W'(held_sel[r]));
            end
        end
    end

    // one safety pass: every customer's remaining claim against the pool
    always_comb begin
        for (int c = 0; c < CUSTOMERS; c++) begin
            fit[c] = !r_retired[c];
            for (int r = 0; r < RESOURCE_TYPES; r++) begin
                need[c][r] = (r_claim[c][r] > r_held[c][r]) ?
                             r_claim[c][r] - r_held[c][r] : '0;
                if (SUM_W'(need[c][r]) > r_pool[r]) begin
                    fit[c] = 1'b0;
                end
            end
        end
        pick = fit & (~fit + CUSTOMERS'(1));
        for (int r = 0; r < RESOURCE_TYPES; r++) begin
            back[r] = '0;
            for (int c = 0; c < CUSTOMERS; c++) begin
                if (pick[c]) begin
                    back[r] = back[r] | SUM_W'(r_held[c][r]);
                end
            end
        end
    end

    assign o_stat.pre_ok   = cust_ok && (&amt_ok);
    assign o_stat.is_req   = is_req;
    assign o_stat.none_fit = (fit == '0);
    assign o_stat.all_done = &(r_retired | pick);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < RESOURCE_TYPES; r++) begin
                r_total[r] <= '0;
                for (int c = 0; c < CUSTOMERS; c++) begin
                    r_claim[c][r] <= '0;
                end
            end
        end else if (i_cfg_we) begin
            for (int r = 0; r < RESOURCE_TYPES; r++) begin
                if (i_cfg_idx == REG_TOTAL_UNITS) begin
                    r_total[r] <= i_cfg_data[FIELD_W*r +: COUNT_WIDTH];
                end
                for (int c = 0; c < CUSTOMERS; c++) begin
                    if (c < CLAIM_REGS && i_cfg_idx == CFG_IDX_W'(REG_MAX_CLAIM0 + c)) begin
                        r_claim[c][r] <= i_cfg_data[FIELD_W*r +: COUNT_WIDTH];
                    end
                end
            end
        end
    end

    // holdings and their per-type sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < RESOURCE_TYPES; r++) begin
                r_used[r] <= '0;
                for (int c = 0; c < CUSTOMERS; c++) begin
                    r_held[c][r] <= '0;
                end
            end
        end else if (held_upd && cust_ok) begin
            for (int r = 0; r < RESOURCE_TYPES; r++) begin
                if (held_add) begin
                    r_used[r] <= r_used[r] + SUM_W'(amt_cnt[r]);
                end else begin
                    r_used[r] <= r_used[r] - SUM_W'(amt_cnt[r]);
                end
                for (int c = 0; c < CUSTOMERS; c++) begin
                    if (sel[c]) begin
                        r_held[c][r] <= held_add ? r_held[c][r] + amt_cnt[r]
                                                 : r_held[c][r] - amt_cnt[r];
                    end
                end
            end
        end
    end

    // safety check work registers
    always_ff @(posedge i_clk) begin
        if (held_add) begin
            r_retired <= '0;
            for (int r = 0; r < RESOURCE_TYPES; r++) begin
                r_pool[r] <= SUM_W'(free_cnt[r]) - SUM_W'(amt_cnt[r]);
            end
        end else if (i_ctl.step) begin
            r_retired <= r_retired | pick;
            for (int r = 0; r < RESOURCE_TYPES; r++) begin
                r_pool[r] <= r_pool[r] + back[r];
            end
        end
    end

    // captured input word and verdict
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd  <= i_cmd;
            r_cust <= i_customer;
            for (int r = 0; r < RESOURCE_TYPES; r++) begin
                r_amt[r] <= amt_in[r];
            end
            r_deny <= 1'b0;
        end else if (i_ctl.deny) begin
            r_deny <= 1'b1;
        end
    end

    for (genvar g = 0; g < MAX_TYPES; g++) begin : g_free
        if (g < RESOURCE_TYPES) begin : g_used
            assign free_ext[g] = FIELD_W'(free_cnt[g]);
        end else begin : g_unused
            assign free_ext[g] = '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_status <= r_deny ? STATUS_DENY : STATUS_OK;
            for (int r = 0; r < MAX_TYPES; r++) begin
                r_free[r] <= free_ext[r];
            end
        end
    end

    assign o_status = r_status;
    assign o_free_a = r_free[0];
    assign o_free_b = r_free[1];
    assign o_free_c = r_free[2];

endmodule

### rtl/bankers_resource_allocator_top.sv
// banker's algorithm allocator: each input word is a request (cmd 0) or a release (cmd 1)
// of up to three resource types by one customer, and each word yields exactly one result
// word with a status (0 granted or released, 1 denied with nothing changed) and the free
// units of each type afterwards. a request must fit the customer's remaining claim and the
// free units, and is then applied tentatively and kept only if a safety check finds an
// order in which every customer can finish; a release must not exceed what is held.
// steps: the word is taken, then checked, then for a request one safety pass per cycle
// follows (each pass retires one customer whose claim fits the pool, at most CUSTOMERS
// passes), an unsafe request is undone, and the output register is loaded. one word
// is in work at a time; the next word is taken while a result waits.
// configuration (totals at index 0, maximum claims at 1..5) resets to zero, is written
// through i_cfg_we/i_cfg_idx/i_cfg_data, and must only change while the block is idle;
// writes to other indexes are ignored
module bankers_resource_allocator_top import bra_pkg::*; #(
    parameter int CUSTOMERS      = 5,
    parameter int RESOURCE_TYPES = 3,
    parameter int COUNT_WIDTH    = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // input word
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_cmd,
    input  logic [CUST_W-1:0]    i_customer,
    input  logic [AMT_W-1:0]     i_amount_a,
    input  logic [AMT_W-1:0]     i_amount_b,
    input  logic [AMT_W-1:0]     i_amount_c,
    // result word
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_status,
    output logic [FIELD_W-1:0]   o_free_a,
    output logic [FIELD_W-1:0]   o_free_b,
    output logic [FIELD_W-1:0]   o_free_c
);

    t_dp_cmd  ctl;   // step commands from the controller
    t_dp_stat stat;  // check results back from the datapath

    // sequencer: check, safety passes, undo, result handoff
    bra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_ctl       (ctl)
    );

    // tables, holdings, safety pool and output register
    bra_datapath #(
        .CUSTOMERS      (CUSTOMERS),
        .RESOURCE_TYPES (RESOURCE_TYPES),
        .COUNT_WIDTH    (COUNT_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (i_cmd),
        .i_customer (i_customer),
        .i_amount_a (i_amount_a),
        .i_amount_b (i_amount_b),
        .i_amount_c (i_amount_c),
        .i_ctl      (ctl),
        .o_stat     (stat),
        .o_status   (o_status),
        .o_free_a   (o_free_a),
        .o_free_b   (o_free_b),
        .o_free_c   (o_free_c)
    );

endmodule

### rtl/bra_checker.sv
`include "bankers_resource_allocator_top_defines.svh"

module bra_checker import bra_pkg::*; #(
    parameter int RESOURCE_TYPES = 3,
    parameter int COUNT_WIDTH    = 8
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic               o_status,
    input logic [FIELD_W-1:0] o_free_a,
    input logic [FIELD_W-1:0] o_free_b,
    input logic [FIELD_W-1:0] o_free_c
);

    // a waiting result holds
    `BRA_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_status) && $stable(o_free_a) && $stable(o_free_b) && $stable(o_free_c), "result word changed while stalled")

    // one word at a time: busy right after taking a word
    `BRA_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready, "input taken while a word is in work")

    // a new result only comes out of a busy period
    `BRA_ASSERT_IMPL(a_result_after_work, $rose(o_out_valid), $past(!o_in_ready), "result without work")

    // free counts fit the count width and unused types read zero
    `BRA_ASSERT_IMPL(a_free_range, o_out_valid, ((o_free_a >> COUNT_WIDTH) == 0) && ((o_free_b >> COUNT_WIDTH) == 0) && ((o_free_c >> COUNT_WIDTH) == 0) && (RESOURCE_TYPES > 2 || o_free_c == 0) && (RESOURCE_TYPES > 1 || o_free_b == 0), "free count out of range")

endmodule

bind bankers_resource_allocator_top bra_checker #(
    .RESOURCE_TYPES (RESOURCE_TYPES),
    .COUNT_WIDTH    (COUNT_WIDTH)
) u_bra_checker (.*);

### sim/tb_bankers_resource_allocator_top.sv
`timescale 1ns / 100ps

module tb_bankers_resource_allocator_top;
    import bra_pkg::*;

    localparam int NUM_CUST      = 5;
    localparam int NUM_TYPES     = 3;
    localparam int RAND_PHASES   = 12;
    localparam int PHASE_WORDS   = 128;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 300;

    // register indexes past the end of the list, the block must ignore them
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = CFG_IDX_W'(REG_MAX_CLAIM0 + CLAIM_REGS);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = '1;

    typedef struct packed {
        logic                              cmd;
        logic [CUST_W-1:0]                 customer;
        logic [NUM_TYPES-1:0][AMT_W-1:0]   amount;
    } t_word;

    typedef struct packed {
        logic                              status;
        logic [NUM_TYPES-1:0][FIELD_W-1:0] free;
    } t_result;

    // directed table rows: a register write, a word checked against the predictor,
    // or a word whose result is typed in
    typedef enum logic [1:0] {
        ROW_REG,
        ROW_PRED,
        ROW_KNOWN
    } t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_W-1:0]       data;
        t_word                  word;
        t_result                known;
    } t_row;

    // clock, reset and all block inputs start at known values
    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_cmd      = CMD_REQUEST;
    logic [CUST_W-1:0]    i_customer = '0;
    logic [AMT_W-1:0]     i_amount_a = '0;
    logic [AMT_W-1:0]     i_amount_b = '0;
    logic [AMT_W-1:0]     i_amount_c = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic                 o_status;
    logic [FIELD_W-1:0]   o_free_a;
    logic [FIELD_W-1:0]   o_free_b;
    logic [FIELD_W-1:0]   o_free_c;

    // predictor copy of the configuration and the holdings table
    logic [NUM_TYPES-1:0][7:0] total_cfg;
    logic [NUM_TYPES-1:0][7:0] claim_cfg [NUM_CUST];
    logic [7:0]                held_tab  [NUM_CUST][NUM_TYPES];

    t_result     pending_results [$];
    int          mismatch_count = 0;

    // idling knobs for the sender and the receiver
    int unsigned src_gap_max  = 7;
    int unsigned sink_gap_max = 7;
    bit          sink_hold_req = 1'b0;

    bankers_resource_allocator_top #(
        .CUSTOMERS      (NUM_CUST),
        .RESOURCE_TYPES (NUM_TYPES),
        .COUNT_WIDTH    (8)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_customer  (i_customer),
        .i_amount_a  (i_amount_a),
        .i_amount_b  (i_amount_b),
        .i_amount_c  (i_amount_c),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_free_a    (o_free_a),
        .o_free_b    (o_free_b),
        .o_free_c    (o_free_c)
    );

    // 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // free units of one type: total minus everything held, floored at zero
    function automatic int free_units(int r);
        int sum;
        int tot;
        sum = 0;
        tot = total_cfg[r];
        for (int c = 0; c < NUM_CUST; c++)
            sum += held_tab[c][r];
        return (tot > sum) ? tot - sum : 0;
    endfunction

    // what a customer may still ask for, floored at zero if the claim was lowered
    function automatic int claim_room(int c, int r);
        int m;
        int h;
        m = claim_cfg[c][r];
        h = held_tab[c][r];
        return (m > h) ? m - h : 0;
    endfunction

    // safety check: retire customers one by one, lowest index first, while the pool covers them
    function automatic bit holdings_are_safe();
        int pool [NUM_TYPES];
        bit retired [NUM_CUST];
        int pick;
        bit fits;
        for (int r = 0; r < NUM_TYPES; r++)
            pool[r] = free_units(r);
        for (int c = 0; c < NUM_CUST; c++)
            retired[c] = 1'b0;
        for (int pass = 0; pass < NUM_CUST; pass++) begin
            pick = -1;
            for (int c = 0; c < NUM_CUST && pick < 0; c++) begin
                fits = !retired[c];
                for (int r = 0; r < NUM_TYPES; r++)
                    if (claim_room(c, r) > pool[r])
                        fits = 1'b0;
                if (fits)
                    pick = c;
            end
            if (pick < 0)
                return 1'b0;
            for (int r = 0; r < NUM_TYPES; r++)
                pool[r] += held_tab[pick][r];
            retired[pick] = 1'b1;
        end
        return 1'b1;
    endfunction

    // applies one word to the holdings and returns the result word it should produce
    function automatic t_result allocate_word(t_word w);
        t_result res;
        bit      ok;
        int      c;
        ok = 1'b1;
        res.status = STATUS_DENY;
        if (w.customer < NUM_CUST) begin
            c = w.customer;
            if (w.cmd == CMD_REQUEST) begin
                for (int r = 0; r < NUM_TYPES; r++)
                    if (w.amount[r] > claim_room(c, r) || w.amount[r] > free_units(r))
                        ok = 1'b0;
                if (ok) begin
                    // tentative grant, rolled back when unsafe
                    for (int r = 0; r < NUM_TYPES; r++)
                        held_tab[c][r] = held_tab[c][r] + w.amount[r];
                    if (holdings_are_safe()) begin
                        res.status = STATUS_OK;
                    end else begin
                        for (int r = 0; r < NUM_TYPES; r++)
                            held_tab[c][r] = held_tab[c][r] - w.amount[r];
                    end
                end
            end else begin
                // release is checked against the holding only
                for (int r = 0; r < NUM_TYPES; r++)
                    if (w.amount[r] > held_tab[c][r])
                        ok = 1'b0;
                if (ok) begin
                    for (int r = 0; r < NUM_TYPES; r++)
                        held_tab[c][r] = held_tab[c][r] - w.amount[r];
                    res.status = STATUS_OK;
                end
            end
        end
        for (int r = 0; r < NUM_TYPES; r++)
            res.free[r] = FIELD_W'(free_units(r));
        return res;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        if (idx == REG_TOTAL_UNITS)
            total_cfg = data;
        else if (idx >= REG_MAX_CLAIM0 && idx < REG_UNUSED_LO)
            claim_cfg[idx - REG_MAX_CLAIM0] = data;
    endfunction

    // ------------------------------------------------------------------
    // table helpers
    // ------------------------------------------------------------------

    function automatic logic [CFG_W-1:0] pack3(int a, int b, int c);
        return {8'(c), 8'(b), 8'(a)};
    endfunction

    function automatic t_row word_row(logic cmd, int cust, int a, int b, int c);
        t_row row;
        row.kind        = ROW_PRED;
        row.idx         = '0;
        row.data        = '0;
        row.word.cmd      = cmd;
        row.word.customer = CUST_W'(cust);
        row.word.amount   = pack3(a, b, c);
        row.known       = '0;
        return row;
    endfunction

    function automatic t_row known_row(logic cmd, int cust, int a, int b, int c,
                                       logic st, int fa, int fb, int fc);
        t_row row;
        row = word_row(cmd, cust, a, b, c);
        row.kind         = ROW_KNOWN;
        row.known.status = st;
        row.known.free   = pack3(fa, fb, fc);
        return row;
    endfunction

    function automatic t_row reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        t_row row;
        row.kind  = ROW_REG;
        row.idx   = idx;
        row.data  = data;
        row.word  = '0;
        row.known = '0;
        return row;
    endfunction

    // mostly a modest count, sometimes an extreme
    function automatic int pick_count(int top);
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(0, (top > 255) ? 255 : top);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // drivers, all at the rising edge with nonblocking assignments
    // ------------------------------------------------------------------

    // one register write; the caller lowers the write enable after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        apply_reg(idx, data);
    endtask

    // offers one word after a random gap; valid stays high on return so that a
    // back-to-back word does not drop it in the same step
    task automatic send_word(input t_word w, input bit has_known, input t_result known);
        int      gap;
        t_result res;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= w.cmd;
        i_customer <= w.customer;
        i_amount_a <= w.amount[0];
        i_amount_b <= w.amount[1];
        i_amount_c <= w.amount[2];
        do @(posedge i_clk); while (!o_in_ready);
        // accepted at this edge: the predictor always advances, typed rows override
        res = allocate_word(w);
        pending_results.push_back(has_known ? known : res);
    endtask

    // sender pause: nothing offered until every pending result word has come out
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // receiver: random stall before each result word, one long hold on request
    initial begin : result_sink
        int hold;
        @(posedge i_clk);
        forever begin
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                hold = LONG_HOLD;
            end else begin
                hold = $urandom_range(0, sink_gap_max);
            end
            if (hold > 0) begin
                i_out_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // checker: every result word against the oldest pending expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing pending: status %0d free %0d %0d %0d",
                       o_status, o_free_a, o_free_b, o_free_c);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatch_count++;
                end
                if (o_free_a !== want.free[0]) begin
                    $error("free_a: expected %0d, got %0d", want.free[0], o_free_a);
                    mismatch_count++;
                end
                if (o_free_b !== want.free[1]) begin
                    $error("free_b: expected %0d, got %0d", want.free[1], o_free_b);
                    mismatch_count++;
                end
                if (o_free_c !== want.free[2]) begin
                    $error("free_c: expected %0d, got %0d", want.free[2], o_free_c);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_row  rows [$];
        t_word w;
        int    cap;
        int    sel;
        int    c;
        logic [NUM_TYPES-1:0][7:0] tot_pick;
        logic [NUM_TYPES-1:0][7:0] claim_pick;

        total_cfg = '0;
        for (int k = 0; k < NUM_CUST; k++) begin
            claim_cfg[k] = '0;
            for (int r = 0; r < NUM_TYPES; r++)
                held_tab[k][r] = '0;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // right after reset: all totals and claims zero
        rows.push_back(known_row(CMD_REQUEST, 0, 0, 0, 0, STATUS_OK, 0, 0, 0));
        rows.push_back(known_row(CMD_REQUEST, 0, 255, 255, 255, STATUS_DENY, 0, 0, 0));
        rows.push_back(known_row(CMD_RELEASE, 4, 0, 0, 0, STATUS_OK, 0, 0, 0));
        rows.push_back(known_row(CMD_RELEASE, 1, 255, 255, 255, STATUS_DENY, 0, 0, 0));
        // customer out of range
        rows.push_back(known_row(CMD_REQUEST, 5, 0, 0, 0, STATUS_DENY, 0, 0, 0));
        rows.push_back(known_row(CMD_RELEASE, 7, 1, 2, 3, STATUS_DENY, 0, 0, 0));

        // everything at full scale, plus writes past the end of the register list
        rows.push_back(reg_row(REG_TOTAL_UNITS, '1));
        for (int k = 0; k < CLAIM_REGS; k++)
            rows.push_back(reg_row(CFG_IDX_W'(REG_MAX_CLAIM0 + k), '1));
        rows.push_back(reg_row(REG_UNUSED_LO, 24'h5A5A5A));
        rows.push_back(reg_row(REG_UNUSED_HI, 24'hA5A5A5));
        rows.push_back(known_row(CMD_REQUEST, 4, 255, 255, 255, STATUS_OK, 0, 0, 0));
        rows.push_back(known_row(CMD_REQUEST, 1, 1, 0, 0, STATUS_DENY, 0, 0, 0));
        rows.push_back(known_row(CMD_RELEASE, 4, 255, 255, 255, STATUS_OK, 255, 255, 255));
        rows.push_back(word_row(CMD_REQUEST, 2, 128, 64, 1));
        // fits claim and pool but leaves nobody able to finish
        rows.push_back(word_row(CMD_REQUEST, 3, 100, 100, 100));
        rows.push_back(word_row(CMD_REQUEST, 0, 0, 1, 2));
        rows.push_back(word_row(CMD_RELEASE, 2, 0, 0, 1));
        rows.push_back(word_row(CMD_RELEASE, 2, 200, 0, 0));

        // totals under the holdings for two types, customer 0 claim lowered to zero,
        // customer 3 claim that can never be met so the state is unsafe
        rows.push_back(reg_row(REG_TOTAL_UNITS, pack3(10, 20, 30)));
        rows.push_back(reg_row(REG_MAX_CLAIM0, '0));
        rows.push_back(reg_row(CFG_IDX_W'(REG_MAX_CLAIM0 + 1), pack3(5, 5, 5)));
        rows.push_back(reg_row(CFG_IDX_W'(REG_MAX_CLAIM0 + 2), pack3(5, 5, 5)));
        rows.push_back(reg_row(CFG_IDX_W'(REG_MAX_CLAIM0 + 3), '1));
        rows.push_back(reg_row(CFG_IDX_W'(REG_MAX_CLAIM0 + 4), pack3(5, 5, 5)));
        // empty request while unsafe
        rows.push_back(word_row(CMD_REQUEST, 1, 0, 0, 0));
        // release beyond the (lowered) claim
        rows.push_back(word_row(CMD_RELEASE, 0, 0, 1, 2));
        rows.push_back(word_row(CMD_RELEASE, 2, 128, 64, 0));
        rows.push_back(word_row(CMD_REQUEST, 3, 10, 0, 0));

        foreach (rows[k]) begin
            if (rows[k].kind == ROW_REG) begin
                // writes only once the block has gone idle
                if (k == 0 || rows[k-1].kind != ROW_REG)
                    wait_idle();
                write_reg(rows[k].idx, rows[k].data);
                if (k + 1 == rows.size() || rows[k+1].kind != ROW_REG)
                    i_cfg_we <= 1'b0;
            end else begin
                send_word(rows[k].word, rows[k].kind == ROW_KNOWN, rows[k].known);
            end
        end

        // random phases, each with its own configuration and idling mix
        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_idle();
            src_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 7;
            sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
            if (p == 0) begin
                src_gap_max  = 7;
                sink_gap_max = 7;
            end
            // one phase with a flat-out sender against a long receiver hold,
            // so the block fills up and stalls its input
            if (p == 4) begin
                src_gap_max   = 0;
                sink_hold_req = 1'b1;
            end

            for (int r = 0; r < NUM_TYPES; r++)
                tot_pick[r] = (p == 0) ? 8'd255 : (p == 1) ? 8'd0 : 8'(pick_count(40));
            write_reg(REG_TOTAL_UNITS, tot_pick);
            for (int k = 0; k < CLAIM_REGS; k++) begin
                for (int r = 0; r < NUM_TYPES; r++)
                    claim_pick[r] = (p == 0) ? 8'd255 : (p == 1) ? 8'd0 :
                                    8'(pick_count(tot_pick[r] + 5));
                write_reg(CFG_IDX_W'(REG_MAX_CLAIM0 + k), claim_pick);
            end
            write_reg(($urandom_range(0, 1) != 0) ? REG_UNUSED_LO : REG_UNUSED_HI,
                      CFG_W'($urandom));
            i_cfg_we <= 1'b0;

            for (int n = 0; n < PHASE_WORDS; n++) begin
                sel   = $urandom_range(0, 9);
                w.cmd = ($urandom_range(0, 1) != 0) ? CMD_RELEASE : CMD_REQUEST;
                if (sel < 7) begin
                    // well-formed: amounts within claim and, on a coin flip, the pool, or within holding
                    c = $urandom_range(0, NUM_CUST - 1);
                    w.customer = CUST_W'(c);
                    for (int r = 0; r < NUM_TYPES; r++) begin
                        if (w.cmd == CMD_REQUEST) begin
                            cap = claim_room(c, r);
                            if ($urandom_range(0, 1) != 0 && free_units(r) < cap)
                                cap = free_units(r);
                        end else begin
                            cap = held_tab[c][r];
                        end
                        w.amount[r] = AMT_W'($urandom_range(0, cap));
                    end
                end else begin
                    // noise: any amount, and now and then any customer code
                    w.customer = (sel == 9) ? CUST_W'($urandom_range(0, 7)) :
                                              CUST_W'($urandom_range(0, NUM_CUST - 1));
                    for (int r = 0; r < NUM_TYPES; r++)
                        w.amount[r] = AMT_W'($urandom_range(0, 255));
                end
                send_word(w, 1'b0, '0);
                // occasional sender pause until the pipe is empty
                if ($urandom_range(0, 63) == 0)
                    wait_idle();
            end
        end

        wait_idle();
        if (pending_results.size() != 0) begin
            $error("%0d result words never arrived", pending_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin : watchdog
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
